@@ hw/rtl/wrsq_pkg.sv @@
// Package for the windowed random step sequencer.
// Holds opcodes, register indexes, reset values and the window control struct.
// No dependencies.
package wrsq_pkg;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic {
		CFG_CV_SCALE    = 1'b0,
		CFG_PULSE_TICKS = 1'b1
	} cfg_reg_t;

	localparam int unsigned VAL_W   = 16;
	localparam int unsigned FIELD_W = 5;
	localparam int unsigned SPAN_W  = 6;
	localparam int unsigned CNT_W   = 32;

	localparam logic signed [VAL_W-1:0] CV_SCALE_RST    = 16'sd3277;
	localparam logic        [VAL_W-1:0] PULSE_TICKS_RST = 16'd48;

	typedef struct packed {
		logic rev;
		logic eos_hit;
	} win_ctl_t;

endpackage

@@ hw/rtl/wrsq_table.sv @@
// Value table: flop array with one write port and one asynchronous read port.
// Depends on wrsq_pkg.
module wrsq_table
	import wrsq_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [FIELD_W-1:0]             waddr,
	input  logic [VAL_W-1:0]               wdata,
	input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
	output logic [VAL_W-1:0]               rdata
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned XW = (IW > FIELD_W) ? IW : FIELD_W;

	logic [VAL_W-1:0] mem_q [TABLE_DEPTH];
	logic [XW:0]      waddr_x;
	logic             waddr_ok;

	assign waddr_x  = (XW+1)'(waddr);
	assign waddr_ok = waddr_x < (XW+1)'(TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (we && waddr_ok) begin
			mem_q[waddr_x[IW-1:0]] <= wdata;
		end
	end

	assign rdata = mem_q[raddr];

endmodule

@@ hw/rtl/wrsq_window.sv @@
// Play window: bounds from start and span, pull-in, step and reset of the index.
// Depends on wrsq_pkg.
module wrsq_window
	import wrsq_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic [$clog2(TABLE_DEPTH)-1:0] play_index,
	input  logic [FIELD_W-1:0]             start_index,
	input  logic signed [SPAN_W-1:0]       span,
	input  logic                           step_en,
	input  logic                           reset_edge,
	output logic [$clog2(TABLE_DEPTH)-1:0] read_index,
	output logic [$clog2(TABLE_DEPTH)-1:0] next_index,
	output win_ctl_t                       ctl
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned XW = (IW > FIELD_W) ? IW : FIELD_W;
	localparam int unsigned AW = XW + 2;
	localparam logic signed [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);
	localparam logic signed [AW-1:0] DEPTH_A = AW'(TABLE_DEPTH);
	localparam logic [IW-1:0]        LAST_I  = IW'(TABLE_DEPTH - 1);

	logic signed [AW-1:0] start_a, span_a, far_a;
	logic [IW-1:0]        lo, hi, home, p0, stepped;
	logic                 rev, pulled;

	function automatic logic in_win(input logic [IW-1:0] i, input logic [IW-1:0] l,
			input logic [IW-1:0] h);
		if (l <= h) begin
			return (i >= l) && (i <= h);
		end
		return (i >= l) || (i <= h);
	endfunction

	always_comb begin
		start_a = AW'(start_index);
		if (start_a > LAST_A) begin
			start_a = LAST_A;
		end
		span_a = AW'(span);
		if (span_a > LAST_A) begin
			span_a = LAST_A;
		end else if (span_a < -LAST_A) begin
			span_a = -LAST_A;
		end
		far_a = start_a + span_a;
		if (far_a < 0) begin
			far_a = far_a + DEPTH_A;
		end else if (far_a >= DEPTH_A) begin
			far_a = far_a - DEPTH_A;
		end
		rev = span_a < 0;
		if (rev) begin
			lo = far_a[IW-1:0];
			hi = start_a[IW-1:0];
		end else begin
			lo = start_a[IW-1:0];
			hi = far_a[IW-1:0];
		end
		home = rev ? hi : lo;

		p0 = ((IW+1)'(play_index) >= (IW+1)'(TABLE_DEPTH)) ? lo : play_index;
		read_index = in_win(p0, lo, hi) ? p0 : home;

		if (rev) begin
			stepped = (read_index == '0) ? LAST_I : read_index - 1'b1;
		end else begin
			stepped = (read_index == LAST_I) ? '0 : read_index + 1'b1;
		end
		pulled = !in_win(stepped, lo, hi);
		if (pulled) begin
			stepped = home;
		end

		next_index = step_en ? stepped : read_index;
		if (reset_edge) begin
			next_index = home;
		end

		ctl.rev     = rev;
		ctl.eos_hit = step_en && pulled;
	end

endmodule

@@ hw/rtl/wrsq_value.sv @@
// Value path: filter window on the table value and scaling to the CV output.
// Depends on wrsq_pkg.
module wrsq_value
	import wrsq_pkg::*;
(
	input  logic [VAL_W-1:0]        raw_value,
	input  logic signed [VAL_W-1:0] filter,
	input  logic signed [VAL_W-1:0] cv_scale,
	output logic [VAL_W-1:0]        value,
	output logic signed [VAL_W-1:0] cv
);

	logic signed [VAL_W+1:0]   v_e, f2;
	logic signed [VAL_W:0]     mul_a, mul_b, scale_e;
	logic signed [2*VAL_W+1:0] prod;

	always_comb begin
		v_e = $signed({2'b00, raw_value});
		f2  = (VAL_W+2)'(filter) <<< 1;
		value = raw_value;
		if (filter > 0 && v_e < f2) begin
			value = '0;
		end
		if (filter < 0 && v_e > (f2 + $signed((VAL_W+2)'(1 << VAL_W)))) begin
			value = '0;
		end

		scale_e = (VAL_W+1)'(cv_scale);
		if (cv_scale < 0) begin
			mul_a = $signed({1'b0, value}) - $signed((VAL_W+1)'(1 << (VAL_W-1)));
			mul_b = -scale_e;
		end else begin
			mul_a = $signed({1'b0, value});
			mul_b = scale_e;
		end
		prod = mul_a * mul_b;
		cv   = prod[2*VAL_W-1:VAL_W];
	end

endmodule

@@ hw/rtl/windowed_random_step_sequencer.sv @@
// Top level of the windowed random step sequencer: input register, tick logic,
// state registers and result register. Depends on wrsq_pkg, wrsq_table,
// wrsq_window and wrsq_value.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | opcode, load_addr, load_value, clock_edge,
//          |                      | run_toggle, reset_edge, start_index, span,
//          |                      | filter
//  out     | out_valid / out_stall| step_index, cv_out, gate_on, trigger_on,
//          |                      | eos_on, running
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle unless in_stall holds the input; each passes the input
// register, then the result register. A transaction is evaluated combinationally
// between the input register and the result register; the table read and the two
// multipliers set the path. The input register keeps accepting while a result
// waits; stall reaches the input only when both registers are full. Reset clears
// run, index, counters and gate state; the table holds nothing until loaded.
module windowed_random_step_sequencer
	import wrsq_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [VAL_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic [FIELD_W-1:0]        load_addr,
	input  logic [VAL_W-1:0]          load_value,
	input  logic                      clock_edge,
	input  logic                      run_toggle,
	input  logic                      reset_edge,
	input  logic [FIELD_W-1:0]        start_index,
	input  logic signed [SPAN_W-1:0]  span,
	input  logic signed [VAL_W-1:0]   filter,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [FIELD_W-1:0]        step_index,
	output logic signed [VAL_W-1:0]   cv_out,
	output logic                      gate_on,
	output logic                      trigger_on,
	output logic                      eos_on,
	output logic                      running
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned XW = (IW > FIELD_W) ? IW : FIELD_W;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// input register
	logic                     valid_s1;
	logic                     opcode_s1;
	logic [FIELD_W-1:0]       load_addr_s1;
	logic [VAL_W-1:0]         load_value_s1;
	logic                     clock_edge_s1, run_toggle_s1, reset_edge_s1;
	logic [FIELD_W-1:0]       start_index_s1;
	logic signed [SPAN_W-1:0] span_s1;
	logic signed [VAL_W-1:0]  filter_s1;

	// result register
	logic                     out_valid_s2;
	logic [FIELD_W-1:0]       step_index_s2;
	logic signed [VAL_W-1:0]  cv_s2;
	logic                     gate_s2, trig_s2, eos_s2, run_s2;

	// state
	logic signed [VAL_W-1:0]  cv_scale_q;
	logic [VAL_W-1:0]         pulse_ticks_q;
	logic [IW-1:0]            play_q;
	logic                     run_q, gate_q, stepped_once_q;
	logic [VAL_W-1:0]         eos_cnt_q, trig_cnt_q;
	logic [CNT_W-1:0]         tsc_q, gate_elapsed_q, gate_limit_q;

	logic                     accept, fire, tick, load, run_next, step_en, step_fire;
	logic [IW-1:0]            read_idx, next_idx, play_next;
	logic [XW-1:0]            play_x;
	win_ctl_t                 win_ctl;
	logic [VAL_W-1:0]         raw_v, filt_v;
	logic signed [VAL_W-1:0]  cv_tick;
	logic [VAL_W-1:0]         eos_arm, trig_arm, eos_cnt_n, trig_cnt_n;
	logic                     eos_now, trig_now;
	logic [CNT_W-1:0]         tsc_inc, ge_inc;
	logic [CNT_W+VAL_W-1:0]   gate_prod;
	logic [CNT_W+VAL_W:0]     gate_round;
	logic [CNT_W-1:0]         gate_limit_new;

	assign fire     = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && out_valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;
	assign tick     = fire && (opcode_s1 == OP_TICK);
	assign load     = fire && (opcode_s1 == OP_LOAD);

	assign run_next  = run_q ^ run_toggle_s1;
	assign step_en   = run_next && clock_edge_s1;
	assign step_fire = tick && step_en;

	wrsq_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (load),
		.waddr (load_addr_s1),
		.wdata (load_value_s1),
		.raddr (read_idx),
		.rdata (raw_v)
	);

	wrsq_window #(.TABLE_DEPTH(TABLE_DEPTH)) u_window (
		.play_index  (play_q),
		.start_index (start_index_s1),
		.span        (span_s1),
		.step_en     (step_en),
		.reset_edge  (reset_edge_s1),
		.read_index  (read_idx),
		.next_index  (next_idx),
		.ctl         (win_ctl)
	);

	wrsq_value u_value (
		.raw_value (raw_v),
		.filter    (filter_s1),
		.cv_scale  (cv_scale_q),
		.value     (filt_v),
		.cv        (cv_tick)
	);

	always_comb begin
		eos_arm  = (win_ctl.eos_hit && eos_cnt_q < pulse_ticks_q) ? pulse_ticks_q : eos_cnt_q;
		trig_arm = (step_en && filt_v != '0 && trig_cnt_q < pulse_ticks_q) ?
			pulse_ticks_q : trig_cnt_q;
		eos_now    = eos_arm != '0;
		trig_now   = trig_arm != '0;
		eos_cnt_n  = eos_now ? eos_arm - 1'b1 : eos_arm;
		trig_cnt_n = trig_now ? trig_arm - 1'b1 : trig_arm;

		tsc_inc = (tsc_q == CNT_MAX) ? tsc_q : tsc_q + 1'b1;
		ge_inc  = (gate_elapsed_q == CNT_MAX) ? gate_elapsed_q : gate_elapsed_q + 1'b1;
		gate_prod      = tsc_inc * filt_v;
		gate_round     = (CNT_W+VAL_W+1)'(gate_prod) + (CNT_W+VAL_W+1)'({VAL_W{1'b1}});
		gate_limit_new = gate_round[CNT_W+VAL_W-1:VAL_W];

		play_next = tick ? next_idx : play_q;
		play_x    = XW'(play_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			out_valid_s2 <= fire || (out_valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1      <= opcode;
			load_addr_s1   <= load_addr;
			load_value_s1  <= load_value;
			clock_edge_s1  <= clock_edge;
			run_toggle_s1  <= run_toggle;
			reset_edge_s1  <= reset_edge;
			start_index_s1 <= start_index;
			span_s1        <= span;
			filter_s1      <= filter;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			step_index_s2 <= play_x[FIELD_W-1:0];
			if (load) begin
				cv_s2   <= '0;
				gate_s2 <= gate_q;
				trig_s2 <= trig_cnt_q != '0;
				eos_s2  <= eos_cnt_q != '0;
				run_s2  <= run_q;
			end else begin
				cv_s2   <= cv_tick;
				trig_s2 <= trig_now;
				eos_s2  <= eos_now;
				run_s2  <= run_next;
				if (step_fire && stepped_once_q) begin
					gate_s2 <= gate_limit_new != '0;
				end else begin
					gate_s2 <= gate_q && (ge_inc < gate_limit_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_scale_q    <= CV_SCALE_RST;
			pulse_ticks_q <= PULSE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CV_SCALE:    cv_scale_q    <= cfg_data;
				CFG_PULSE_TICKS: pulse_ticks_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q         <= '0;
			run_q          <= 1'b0;
			eos_cnt_q      <= '0;
			trig_cnt_q     <= '0;
			tsc_q          <= '0;
			gate_elapsed_q <= '0;
			gate_limit_q   <= '0;
			gate_q         <= 1'b0;
			stepped_once_q <= 1'b0;
		end else if (tick) begin
			play_q     <= next_idx;
			run_q      <= run_next;
			eos_cnt_q  <= eos_cnt_n;
			trig_cnt_q <= trig_cnt_n;
			if (step_en && stepped_once_q) begin
				gate_elapsed_q <= '0;
				gate_limit_q   <= gate_limit_new;
				gate_q         <= gate_limit_new != '0;
			end else if (gate_q) begin
				gate_elapsed_q <= ge_inc;
				if (ge_inc >= gate_limit_q) begin
					gate_q <= 1'b0;
				end
			end
			if (step_en) begin
				tsc_q <= '0;
				if (!stepped_once_q) begin
					stepped_once_q <= 1'b1;
				end
			end else begin
				tsc_q <= tsc_inc;
			end
		end
	end

	assign out_valid  = out_valid_s2;
	assign step_index = step_index_s2;
	assign cv_out     = cv_s2;
	assign gate_on    = gate_s2;
	assign trigger_on = trig_s2;
	assign eos_on     = eos_s2;
	assign running    = run_s2;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1)
		else $error("pending transaction dropped from input register");

	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_s2)
		else $error("evaluated transaction produced no result");

	a_gate_open: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(gate_q) |-> $past(step_fire))
		else $error("gate opened without a step");

	a_result_gate: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> gate_s2 == gate_q)
		else $error("reported gate differs from gate state");

endmodule

@@ tb/tb_windowed_random_step_sequencer.sv @@
// Self-checking testbench for windowed_random_step_sequencer.
// Keeps its own predictor of the sequencer and checks every result transaction.
// Depends on wrsq_pkg and the sequencer RTL only.
module tb_windowed_random_step_sequencer;
	import wrsq_pkg::*;

	localparam int DEPTH       = 32;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		op_t                      op;
		logic [FIELD_W-1:0]       load_addr;
		logic [VAL_W-1:0]         load_value;
		logic                     clock_edge;
		logic                     run_toggle;
		logic                     reset_edge;
		logic [FIELD_W-1:0]       start_index;
		logic signed [SPAN_W-1:0] span;
		logic signed [VAL_W-1:0]  filter;
	} seq_cmd_t;

	typedef struct packed {
		logic [FIELD_W-1:0]      step_index;
		logic signed [VAL_W-1:0] cv_out;
		logic                    gate_on;
		logic                    trigger_on;
		logic                    eos_on;
		logic                    running;
	} seq_out_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_we      = 1'b0;
	logic                     cfg_index   = 1'b0;
	logic [VAL_W-1:0]         cfg_data    = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic                     opcode      = 1'b0;
	logic [FIELD_W-1:0]       load_addr   = '0;
	logic [VAL_W-1:0]         load_value  = '0;
	logic                     clock_edge  = 1'b0;
	logic                     run_toggle  = 1'b0;
	logic                     reset_edge  = 1'b0;
	logic [FIELD_W-1:0]       start_index = '0;
	logic signed [SPAN_W-1:0] span        = '0;
	logic signed [VAL_W-1:0]  filter      = '0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic [FIELD_W-1:0]       step_index;
	logic signed [VAL_W-1:0]  cv_out;
	logic                     gate_on;
	logic                     trigger_on;
	logic                     eos_on;
	logic                     running;

	// predictor state
	logic [VAL_W-1:0]        value_mem [DEPTH];
	int                      cur_index        = 0;
	bit                      run_state        = 1'b0;
	int unsigned             eos_left         = 0;
	int unsigned             trig_left        = 0;
	int unsigned             ticks_since_edge = 0;
	int unsigned             gate_age         = 0;
	int unsigned             gate_len         = 0;
	bit                      gate_open        = 1'b0;
	bit                      first_step_seen  = 1'b0;
	logic signed [VAL_W-1:0] scale_q15        = CV_SCALE_RST;
	logic [VAL_W-1:0]        pulse_len        = PULSE_TICKS_RST;

	seq_out_t    pending_results [$];
	int          mismatches  = 0;
	int          result_hold = 0;
	bit          no_idle     = 1'b0;
	int unsigned cycle_count = 0;

	windowed_random_step_sequencer #(.TABLE_DEPTH(DEPTH)) dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit in_window(input int idx, input int lo, input int hi);
		if (lo <= hi)
			return idx >= lo && idx <= hi;
		return idx >= lo || idx <= hi;
	endfunction

	function automatic seq_out_t sequencer_step(input seq_cmd_t c);
		seq_out_t          r;
		int                st, sp, lo, hi, v, f;
		bit                rev, stepped;
		longint            prod_cv;
		longint unsigned   prod_gate;
		r = '0;
		stepped = 1'b0;
		if (c.op == OP_LOAD) begin
			value_mem[c.load_addr] = c.load_value;
			r.eos_on = eos_left != 0;
			r.trigger_on = trig_left != 0;
		end else begin
			if (c.run_toggle)
				run_state = !run_state;
			st = int'(c.start_index);
			sp = int'(c.span);
			if (sp > DEPTH - 1)
				sp = DEPTH - 1;
			if (sp < -(DEPTH - 1))
				sp = -(DEPTH - 1);
			rev = sp < 0;
			if (rev) begin
				lo = (st + sp) & (DEPTH - 1);
				hi = st;
			end else begin
				lo = st;
				hi = (st + sp) & (DEPTH - 1);
			end
			if (!in_window(cur_index, lo, hi))
				cur_index = rev ? hi : lo;

			v = int'(value_mem[cur_index]);
			f = int'(c.filter);
			if (f > 0 && v < 2 * f)
				v = 0;
			if (f < 0 && v > 65536 + 2 * f)
				v = 0;

			if (run_state && c.clock_edge) begin
				cur_index = rev ? (cur_index + DEPTH - 1) % DEPTH : (cur_index + 1) % DEPTH;
				stepped = 1'b1;
				if (!in_window(cur_index, lo, hi)) begin
					cur_index = rev ? hi : lo;
					if (eos_left < pulse_len)
						eos_left = 32'(pulse_len);
				end
				if (v > 0 && trig_left < pulse_len)
					trig_left = 32'(pulse_len);
			end
			if (c.reset_edge)
				cur_index = rev ? hi : lo;

			r.eos_on = eos_left != 0;
			if (eos_left != 0)
				eos_left--;
			r.trigger_on = trig_left != 0;
			if (trig_left != 0)
				trig_left--;

			if (scale_q15 >= 0)
				prod_cv = longint'(v) * longint'(scale_q15);
			else
				prod_cv = (longint'(v) - 32768) * (-longint'(scale_q15));
			r.cv_out = 16'(prod_cv >>> 16);

			if (ticks_since_edge != 32'hFFFF_FFFF)
				ticks_since_edge++;
			if (gate_open) begin
				if (gate_age != 32'hFFFF_FFFF)
					gate_age++;
				if (gate_age >= gate_len)
					gate_open = 1'b0;
			end
			if (stepped) begin
				if (first_step_seen) begin
					prod_gate = longint'(ticks_since_edge) * longint'(v);
					gate_age = 0;
					gate_len = 32'((prod_gate + 65535) >> 16);
					gate_open = gate_len != 0;
				end else begin
					first_step_seen = 1'b1;
				end
				ticks_since_edge = 0;
			end
		end
		r.step_index = 5'(cur_index);
		r.gate_on = gate_open;
		r.running = run_state;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic seq_cmd_t random_cmd();
		seq_cmd_t c;
		c.op          = op_t'($urandom_range(0, 1));
		c.load_addr   = FIELD_W'($urandom);
		c.load_value  = VAL_W'($urandom);
		c.clock_edge  = 1'($urandom_range(0, 1));
		c.run_toggle  = 1'($urandom_range(0, 1));
		c.reset_edge  = 1'($urandom_range(0, 1));
		c.start_index = FIELD_W'($urandom);
		c.span        = SPAN_W'($urandom);
		c.filter      = VAL_W'($urandom);
		return c;
	endfunction

	task automatic send_cmd(input seq_cmd_t c);
		int gap;
		bit taken;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= c.op;
		load_addr   <= c.load_addr;
		load_value  <= c.load_value;
		clock_edge  <= c.clock_edge;
		run_toggle  <= c.run_toggle;
		reset_edge  <= c.reset_edge;
		start_index <= c.start_index;
		span        <= c.span;
		filter      <= c.filter;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		pending_results.insert(pending_results.size(), sequencer_step(c));
	endtask

	task automatic send_tick(input logic [FIELD_W-1:0] st, input logic signed [SPAN_W-1:0] sp,
			input logic signed [VAL_W-1:0] flt, input bit ce, input bit rt, input bit re);
		seq_cmd_t c;
		c = random_cmd();
		c.op          = OP_TICK;
		c.start_index = st;
		c.span        = sp;
		c.filter      = flt;
		c.clock_edge  = ce;
		c.run_toggle  = rt;
		c.reset_edge  = re;
		send_cmd(c);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [VAL_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == CFG_CV_SCALE)
			scale_q15 = data;
		else
			pulse_len = data;
	endtask

	task automatic run_phrase(input int n_items);
		seq_cmd_t                 c;
		logic [FIELD_W-1:0]       st;
		logic signed [SPAN_W-1:0] sp;
		logic signed [VAL_W-1:0]  flt;
		int                       k, every;
		st = FIELD_W'($urandom);
		sp = SPAN_W'($urandom);
		every = $urandom_range(1, 6);
		case ($urandom_range(0, 9))
		0, 1, 2, 3: flt = '0;
		4, 5, 6:    flt = VAL_W'($urandom_range(1, 8000));
		7, 8:       flt = VAL_W'(-int'($urandom_range(1, 8000)));
		default:    flt = VAL_W'($urandom);
		endcase
		for (k = 0; k < n_items; k++) begin
			c = random_cmd();
			if ($urandom_range(0, 9) != 0) begin
				c.op          = ($urandom_range(0, 19) == 0) ? OP_LOAD : OP_TICK;
				c.start_index = st;
				c.span        = sp;
				c.filter      = flt;
				c.clock_edge  = ($urandom_range(1, every) == 1);
				c.run_toggle  = (k == 0) ? !run_state : ($urandom_range(0, 29) == 0);
				c.reset_edge  = ($urandom_range(0, 29) == 0);
			end
			send_cmd(c);
		end
	endtask

	task automatic test_table_load();
		seq_cmd_t c;
		int k;
		for (k = 0; k < DEPTH; k++) begin
			c = random_cmd();
			c.op = OP_LOAD;
			c.load_addr = 5'(k);
			case (k)
			0: c.load_value = 16'h0000;
			1: c.load_value = 16'hFFFF;
			2: c.load_value = 16'h0001;
			3: c.load_value = 16'd8000;
			4: c.load_value = 16'h7FFF;
			default: ;
			endcase
			send_cmd(c);
		end
		wait_results_done();
	endtask

	task automatic test_window_edges();
		int k;
		send_tick(5'd0, 6'sd5, 16'sd0, 1'b1, 1'b0, 1'b0);
		send_tick(5'd0, 6'sd5, 16'sd0, 1'b1, 1'b1, 1'b0);
		for (k = 0; k < 6; k++)
			send_tick(5'd0, 6'sd5, 16'sd0, 1'b1, 1'b0, 1'b0);
		for (k = 0; k < 4; k++)
			send_tick(5'd30, 6'sd3, 16'sd0, 1'b1, 1'b0, 1'b0);
		for (k = 0; k < 3; k++)
			send_tick(5'd31, -6'sd32, 16'sd0, 1'b1, 1'b0, 1'b0);
		send_tick(5'd31, 6'sd31, 16'sd0, 1'b1, 1'b0, 1'b0);
		send_tick(5'd7, 6'sd0, 16'sd0, 1'b1, 1'b0, 1'b0);
		send_tick(5'd7, 6'sd0, 16'sd0, 1'b1, 1'b0, 1'b0);
		send_tick(5'd10, 6'sd4, 16'sd0, 1'b1, 1'b0, 1'b1);
		send_tick(5'd0, 6'sd3, 16'sd32767, 1'b1, 1'b0, 1'b0);
		send_tick(5'd0, 6'sd3, -16'sd32768, 1'b1, 1'b0, 1'b0);
		send_tick(5'd0, 6'sd3, 16'sd1, 1'b1, 1'b0, 1'b0);
		send_tick(5'd0, 6'sd3, -16'sd1, 1'b1, 1'b0, 1'b0);
		send_tick(5'd31, -6'sd1, 16'sd0, 1'b0, 1'b1, 1'b0);
		wait_results_done();
	endtask

	task automatic test_register_extremes();
		logic signed [VAL_W-1:0] s;
		logic [VAL_W-1:0]        p;
		int                      k;
		for (k = 0; k < 5; k++) begin
			case (k)
			0:       begin s = 16'sh7FFF; p = 16'd1;     end
			1:       begin s = 16'sh8000; p = 16'hFFFF;  end
			2:       begin s = 16'sh0000; p = 16'd2;     end
			3:       begin s = 16'shFFFF; p = 16'd300;   end
			default: begin s = CV_SCALE_RST; p = PULSE_TICKS_RST; end
			endcase
			write_reg(CFG_CV_SCALE, s);
			write_reg(CFG_PULSE_TICKS, p);
			run_phrase(20);
			run_phrase(20);
			run_phrase(20);
			wait_results_done();
		end
	endtask

	task automatic test_result_backpressure();
		result_hold = 150;
		no_idle = 1'b1;
		run_phrase(40);
		no_idle = 1'b0;
		// hold input off until every pending transaction is back
		wait_results_done();
	endtask

	task automatic test_random_phrases();
		int sent, n;
		sent = 0;
		while (sent < 460) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 6) == 0) begin
				n = $urandom_range(3, 10);
				repeat (n) send_cmd(random_cmd());
			end else begin
				n = $urandom_range(8, 30);
				run_phrase(n);
			end
			sent += n;
		end
		no_idle = 1'b0;
	endtask

	initial begin : result_stall
		int n;
		forever begin
			@(posedge clk);
			n = (result_hold > 0) ? result_hold : pick_gap();
			result_hold = 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	initial begin : result_check
		seq_out_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: index %0d cv %0d", step_index, cv_out);
				end else begin
					want = pending_results.pop_front();
					if (want.step_index !== step_index || want.cv_out !== cv_out ||
							want.gate_on !== gate_on || want.trigger_on !== trigger_on ||
							want.eos_on !== eos_on || want.running !== running) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"mismatch: expected index %0d cv %0d gate %b trig %b ",
								"eos %b run %b, got index %0d cv %0d gate %b trig %b eos %b run %b"},
								want.step_index, want.cv_out, want.gate_on, want.trigger_on,
								want.eos_on, want.running, step_index, cv_out, gate_on,
								trigger_on, eos_on, running);
					end
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_window_edges();
		test_register_extremes();
		test_result_backpressure();
		test_random_phrases();
		wait_results_done();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/wrsq_pkg.sv
hw/rtl/wrsq_table.sv
hw/rtl/wrsq_window.sv
hw/rtl/wrsq_value.sv
hw/rtl/windowed_random_step_sequencer.sv
tb/tb_windowed_random_step_sequencer.sv
